[rtl/udfu_pkg.sv]
`timescale 1ns / 1ps
package udfu_pkg;

   localparam int ADDR_W  = 23;
   localparam int VALUE_W = 16;
   localparam int LEN_W   = 16;
   localparam int PAY_W   = 48;
   localparam int ACT_W   = 4;
   localparam int BASE_W  = 16;
   localparam int MAX_RES = 3;

   localparam logic [BASE_W-1:0] APP_BASE_RESET = 16'h0400;

   // Event codes.
   localparam logic [1:0] EV_BUS_RESET = 2'd0;
   localparam logic [1:0] EV_OUT_DONE  = 2'd1;
   localparam logic [1:0] EV_SETUP     = 2'd2;

   // Action codes.
   localparam logic [ACT_W-1:0] ACT_EPRESET  = 4'd0;
   localparam logic [ACT_W-1:0] ACT_DEVDESC  = 4'd1;
   localparam logic [ACT_W-1:0] ACT_CFGDESC  = 4'd2;
   localparam logic [ACT_W-1:0] ACT_SEND     = 4'd3;
   localparam logic [ACT_W-1:0] ACT_STALL    = 4'd4;
   localparam logic [ACT_W-1:0] ACT_ZLP      = 4'd5;
   localparam logic [ACT_W-1:0] ACT_SETADDR  = 4'd6;
   localparam logic [ACT_W-1:0] ACT_CFGSTORE = 4'd7;
   localparam logic [ACT_W-1:0] ACT_ERASE    = 4'd8;
   localparam logic [ACT_W-1:0] ACT_WRITE    = 4'd9;

   // Request types.
   localparam logic [7:0] RT_STD_DEVICE    = 8'h00;
   localparam logic [7:0] RT_STD_IFACE_OUT = 8'h01;
   localparam logic [7:0] RT_DFU_CLASS     = 8'h21;

   // Standard request codes.
   localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
   localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
   localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
   localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
   localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
   localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
   localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

   // DFU class request codes.
   localparam logic [7:0] CLS_DOWNLOAD   = 8'd1;
   localparam logic [7:0] CLS_GET_STATUS = 8'd3;
   localparam logic [7:0] CLS_GET_STATE  = 8'd5;

   // Descriptor types.
   localparam logic [7:0] DESC_DEVICE = 8'd1;
   localparam logic [7:0] DESC_CONFIG = 8'd2;

   // DFU states.
   localparam logic [7:0] DFU_STATE_IDLE   = 8'h02;
   localparam logic [7:0] DFU_STATE_DNLOAD = 8'h05;

   typedef struct packed {
      logic [1:0]         event_req;
      logic [7:0]         request_type;
      logic [7:0]         request_code;
      logic [VALUE_W-1:0] request_value;
      logic [LEN_W-1:0]   request_length;
   } req_item_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [LEN_W-1:0]  send_length;
      logic [PAY_W-1:0]  payload;
      logic [ADDR_W-1:0] target_address;
      logic              last;
   } rsp_item_type;

   // One classified item: up to three actions sharing one set of fields.
   typedef struct packed {
      logic [1:0]                    count;
      logic [MAX_RES-1:0][ACT_W-1:0] action;
      logic [LEN_W-1:0]              send_length;
      logic [PAY_W-1:0]              payload;
      logic [ADDR_W-1:0]             target_address;
   } job_type;

endpackage

[rtl/udfu_front.sv]
`timescale 1ns / 1ps
module udfu_front #(
   parameter int PAGE_BYTES    = 64,
   parameter int PAGES_PER_ROW = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  udfu_pkg::req_item_type req_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data,
   output logic                   push,
   output udfu_pkg::job_type      push_job,
   input  logic                   queue_full
);
   import udfu_pkg::*;

   localparam int ROW_BYTES = PAGE_BYTES * PAGES_PER_ROW;
   localparam int ROW_LOG   = $clog2(ROW_BYTES);
   localparam int DIV_SHIFT = ADDR_W + ROW_LOG;
   localparam int RECIP_W   = ADDR_W + 2;
   localparam int PROD_W    = ADDR_W + RECIP_W;
   localparam int OFF_W     = VALUE_W + $clog2(PAGE_BYTES + 1) + 1;
   localparam int REM_W     = ADDR_W + 1;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << DIV_SHIFT) + ROW_BYTES - 1) / ROW_BYTES;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   logic [BASE_W-1:0] app_base_ff;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   req_item_type      s1_item_ff, s2_item_ff, s3_item_ff;
   logic [ADDR_W-1:0] s2_addr_ff, s3_addr_ff, s3_row_ff;

   logic [OFF_W-1:0]  off_sum;
   logic [ADDR_W-1:0] s2_addr_in;
   logic [PROD_W-1:0] recip_prod;
   logic [ADDR_W-1:0] s3_row_in;
   logic [REM_W-1:0]  row_start, row_rem, row_rem_fix;
   logic              row_first;

   logic              advance, fire;

   logic [VALUE_W-1:0] config_value_ff, config_value_in;
   logic               download_mode_ff, download_mode_in;
   logic [ADDR_W-1:0]  pending_addr_ff, pending_addr_in;
   logic               pending_valid_ff, pending_valid_in;
   logic               pending_erase_ff, pending_erase_in;

   job_type    job;
   logic [7:0] dfu_state;
   logic [7:0] type_low;
   logic       arm_write;

   assign csr_ready = 1'b1;
   assign advance   = !(s3_valid_ff && queue_full);
   assign req_stall = !advance;
   assign fire      = s3_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         app_base_ff <= APP_BASE_RESET;
      end else if (csr_valid) begin
         app_base_ff <= csr_data;
      end
   end

   // Page address, then row number by reciprocal multiply, then the remainder.
   always_comb begin
      off_sum    = OFF_W'(s1_item_ff.request_value) * OFF_W'(PAGE_BYTES)
                 + OFF_W'(app_base_ff);
      s2_addr_in = ADDR_W'(off_sum);
      recip_prod = PROD_W'(s2_addr_ff) * PROD_W'(RECIP);
      s3_row_in  = ADDR_W'(recip_prod >> DIV_SHIFT);
      row_start  = REM_W'(s3_row_ff) * REM_W'(ROW_BYTES);
      row_rem    = REM_W'(s3_addr_ff) - row_start;
      if (row_rem >= REM_W'(ROW_BYTES)) begin
         row_rem_fix = row_rem - REM_W'(ROW_BYTES);
      end else begin
         row_rem_fix = row_rem;
      end
      row_first = row_rem_fix < REM_W'(PAGE_BYTES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff <= req_data;
         s2_item_ff <= s1_item_ff;
         s2_addr_ff <= s2_addr_in;
         s3_item_ff <= s2_item_ff;
         s3_addr_ff <= s2_addr_ff;
         s3_row_ff  <= s3_row_in;
      end
   end

   always_comb begin
      job              = '0;
      config_value_in  = config_value_ff;
      download_mode_in = download_mode_ff;
      pending_addr_in  = pending_addr_ff;
      pending_valid_in = pending_valid_ff;
      pending_erase_in = pending_erase_ff;
      dfu_state        = download_mode_ff ? DFU_STATE_DNLOAD : DFU_STATE_IDLE;
      type_low         = {1'b0, s3_item_ff.request_type[6:0]};
      arm_write        = 1'b0;
      case (s3_item_ff.event_req)
         EV_BUS_RESET: begin
            job.count     = 2'd1;
            job.action[0] = ACT_EPRESET;
         end
         EV_OUT_DONE: begin
            if (pending_valid_ff) begin
               job.target_address = pending_addr_ff;
               pending_valid_in   = 1'b0;
               if (pending_erase_ff) begin
                  job.count     = 2'd3;
                  job.action[0] = ACT_ERASE;
                  job.action[1] = ACT_WRITE;
                  job.action[2] = ACT_ZLP;
               end else begin
                  job.count     = 2'd2;
                  job.action[0] = ACT_WRITE;
                  job.action[1] = ACT_ZLP;
               end
            end
         end
         EV_SETUP: begin
            if (s3_item_ff.request_type == RT_STD_IFACE_OUT) begin
               job.count     = 2'd1;
               job.action[0] = ACT_ZLP;
            end else begin
               case (type_low)
                  RT_STD_DEVICE, RT_STD_IFACE_OUT: begin
                     case (s3_item_ff.request_code)
                        REQ_GET_DESCRIPTOR: begin
                           job.count = 2'd1;
                           case (s3_item_ff.request_value[15:8])
                              DESC_DEVICE: begin
                                 job.action[0]   = ACT_DEVDESC;
                                 job.send_length = s3_item_ff.request_length;
                              end
                              DESC_CONFIG: begin
                                 job.action[0]   = ACT_CFGDESC;
                                 job.send_length = s3_item_ff.request_length;
                              end
                              default: begin
                                 job.action[0] = ACT_STALL;
                              end
                           endcase
                        end
                        REQ_GET_CONFIGURATION: begin
                           job.count       = 2'd1;
                           job.action[0]   = ACT_SEND;
                           job.send_length = LEN_W'(1);
                           job.payload     = PAY_W'(config_value_ff[7:0]);
                        end
                        REQ_GET_STATUS: begin
                           job.count       = 2'd1;
                           job.action[0]   = ACT_SEND;
                           job.send_length = LEN_W'(2);
                        end
                        REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                           job.count     = 2'd1;
                           job.action[0] = ACT_STALL;
                        end
                        REQ_SET_ADDRESS: begin
                           job.count          = 2'd2;
                           job.action[0]      = ACT_ZLP;
                           job.action[1]      = ACT_SETADDR;
                           job.target_address =
                              ADDR_W'(s3_item_ff.request_value[6:0]);
                        end
                        REQ_SET_CONFIGURATION: begin
                           config_value_in = s3_item_ff.request_value;
                           job.count       = 2'd2;
                           job.action[0]   = ACT_CFGSTORE;
                           job.action[1]   = ACT_ZLP;
                           job.payload     = PAY_W'(s3_item_ff.request_value);
                        end
                        default: begin
                        end
                     endcase
                  end
                  RT_DFU_CLASS: begin
                     if (s3_item_ff.request_code == CLS_GET_STATUS) begin
                        job.count       = 2'd1;
                        job.action[0]   = ACT_SEND;
                        job.send_length = LEN_W'(6);
                        job.payload     = {8'h00, dfu_state, 32'h0};
                     end else if (s3_item_ff.request_code == CLS_GET_STATE) begin
                        job.count       = 2'd1;
                        job.action[0]   = ACT_SEND;
                        job.send_length = LEN_W'(1);
                        job.payload     = PAY_W'(dfu_state);
                     end else begin
                        if (s3_item_ff.request_code == CLS_DOWNLOAD) begin
                           download_mode_in = 1'b0;
                           if (s3_item_ff.request_length != '0) begin
                              arm_write        = 1'b1;
                              download_mode_in = 1'b1;
                              pending_addr_in  = s3_addr_ff;
                              pending_valid_in = 1'b1;
                              pending_erase_in = row_first;
                           end
                        end
                        if (!(arm_write || pending_valid_ff)) begin
                           job.count     = 2'd1;
                           job.action[0] = ACT_ZLP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         config_value_ff  <= '0;
         download_mode_ff <= 1'b0;
         pending_valid_ff <= 1'b0;
      end else if (fire) begin
         config_value_ff  <= config_value_in;
         download_mode_ff <= download_mode_in;
         pending_valid_ff <= pending_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pending_addr_ff  <= pending_addr_in;
         pending_erase_ff <= pending_erase_in;
      end
   end

   assign push     = fire && (job.count != 2'd0);
   assign push_job = job;

endmodule

[rtl/udfu_queue.sv]
`timescale 1ns / 1ps
module udfu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  udfu_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output udfu_pkg::job_type head_job,
   output logic              empty
);
   import udfu_pkg::*;

   localparam int DEPTH  = 2;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   job_type             entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full     = fill_ff == FILL_W'(DEPTH);
   assign empty    = fill_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/udfu_back.sv]
`timescale 1ns / 1ps
module udfu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  udfu_pkg::job_type      head_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output udfu_pkg::rsp_item_type rsp_data
);
   import udfu_pkg::*;

   logic [1:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;
   logic             load, is_last;
   logic [ACT_W-1:0] act;

   assign load    = !queue_empty && (!rsp_valid_ff || !rsp_stall);
   assign act     = head_job.action[idx_ff];
   assign is_last = idx_ff == (head_job.count - 2'd1);
   assign pop     = load && is_last;

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in.action = act;
      rsp_data_in.last   = is_last;
      if (act != ACT_ZLP) begin
         rsp_data_in.send_length    = head_job.send_length;
         rsp_data_in.payload        = head_job.payload;
         rsp_data_in.target_address = head_job.target_address;
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      idx_in       = idx_ff;
      if (load) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/usb_dfu_control_request_handler.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Beat
// req_      in         req_valid / req_stall  one control endpoint event
// rsp_      out        rsp_valid / rsp_stall  one action, last marks the final one
// csr_      in         csr_valid / csr_ready  app_base write data
//
// An event passes three front stages (page address, row division, decode) and
// then a two-entry queue, and the back end registers each action before it is sent.
// The back end sends one action per cycle unless rsp_ stalls; an event has up to three.
// Reset is synchronous and clears the pipeline, the queue and the stored state at once.
// A stall on rsp_ fills the queue and then stalls req_; csr_ready is always high.
module usb_dfu_control_request_handler #(
   parameter int PAGE_BYTES    = 64,
   parameter int PAGES_PER_ROW = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  udfu_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output udfu_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data
);
   import udfu_pkg::*;

   logic    push, queue_full, pop, queue_empty;
   job_type push_job, head_job;

   udfu_front #(
      .PAGE_BYTES    (PAGE_BYTES),
      .PAGES_PER_ROW (PAGES_PER_ROW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   udfu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   udfu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

[rtl/udfu_chk.sv]
`timescale 1ns / 1ps
module udfu_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input udfu_pkg::rsp_item_type rsp_data
);
   import udfu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.action <= ACT_WRITE)
      else $error("undefined action code");

   a_zlp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == ACT_ZLP |->
         rsp_data.send_length == '0 && rsp_data.payload == '0 &&
         rsp_data.target_address == '0)
      else $error("zero-length packet carries data");

endmodule

bind usb_dfu_control_request_handler udfu_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[bench/tb_usb_dfu_control_request_handler.sv]
`timescale 1ns / 1ps
module tb_usb_dfu_control_request_handler;
   import udfu_pkg::*;

   localparam int PAGE_BYTES    = 64;
   localparam int PAGES_PER_ROW = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 56;
   localparam int BASE_IDLE_PCT = 38;
   localparam int MAX_PRINTS    = 40;

   localparam logic [1:0] EV_UNDEFINED = 2'd3;
   localparam logic [7:0] DIR_IN       = 8'h80;

   class dfu_scoreboard;
      rsp_item_type    expected_q[$];
      logic [15:0]     app_base;
      logic [15:0]     config_value;
      logic            download_mode;
      logic [22:0]     page_addr;
      logic            page_armed;
      int              mismatches;
      int              events_seen;
      int              actions_checked;
      int              erases_seen;

      function new();
         app_base        = APP_BASE_RESET;
         config_value    = '0;
         download_mode   = 1'b0;
         page_addr       = '0;
         page_armed      = 1'b0;
         mismatches      = 0;
         events_seen     = 0;
         actions_checked = 0;
         erases_seen     = 0;
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         if (mismatches < MAX_PRINTS) begin
            $display("%0t mismatch: %s, got %0h, expected %0h", $realtime, what, got, want);
         end
         mismatches++;
      endtask

      function rsp_item_type make_action(logic [ACT_W-1:0] act, logic [LEN_W-1:0] len,
                                         logic [PAY_W-1:0] pay, logic [ADDR_W-1:0] addr);
         rsp_item_type a;
         a.action         = act;
         a.send_length    = len;
         a.payload        = pay;
         a.target_address = addr;
         a.last           = 1'b0;
         return a;
      endfunction

      // Works out the actions that one control endpoint event causes.
      function void note_request(req_item_type req);
         rsp_item_type acts[$];
         logic [7:0]   state_byte;
         logic [7:0]   base_type;
         logic [31:0]  page_sum;
         state_byte = download_mode ? DFU_STATE_DNLOAD : DFU_STATE_IDLE;
         base_type  = req.request_type & ~DIR_IN;
         events_seen++;
         case (req.event_req)
            EV_BUS_RESET: begin
               acts.push_back(make_action(ACT_EPRESET, '0, '0, '0));
            end
            EV_OUT_DONE: begin
               if (page_armed) begin
                  if (((page_addr / PAGE_BYTES) % PAGES_PER_ROW) == 0) begin
                     acts.push_back(make_action(ACT_ERASE, '0, '0, page_addr));
                     erases_seen++;
                  end
                  acts.push_back(make_action(ACT_WRITE, '0, '0, page_addr));
                  acts.push_back(make_action(ACT_ZLP, '0, '0, '0));
                  page_armed = 1'b0;
                  page_addr  = '0;
               end
            end
            EV_SETUP: begin
               if (req.request_type == RT_STD_IFACE_OUT) begin
                  acts.push_back(make_action(ACT_ZLP, '0, '0, '0));
               end else if (base_type == RT_STD_DEVICE || base_type == RT_STD_IFACE_OUT) begin
                  case (req.request_code)
                     REQ_GET_DESCRIPTOR: begin
                        if (req.request_value[15:8] == DESC_DEVICE) begin
                           acts.push_back(make_action(ACT_DEVDESC, req.request_length, '0, '0));
                        end else if (req.request_value[15:8] == DESC_CONFIG) begin
                           acts.push_back(make_action(ACT_CFGDESC, req.request_length, '0, '0));
                        end else begin
                           acts.push_back(make_action(ACT_STALL, '0, '0, '0));
                        end
                     end
                     REQ_GET_CONFIGURATION: begin
                        acts.push_back(make_action(ACT_SEND, 16'd1, {40'h0, config_value[7:0]}, '0));
                     end
                     REQ_GET_STATUS: begin
                        acts.push_back(make_action(ACT_SEND, 16'd2, '0, '0));
                     end
                     REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                        acts.push_back(make_action(ACT_STALL, '0, '0, '0));
                     end
                     REQ_SET_ADDRESS: begin
                        acts.push_back(make_action(ACT_ZLP, '0, '0, '0));
                        acts.push_back(make_action(ACT_SETADDR, '0, '0,
                                                   {16'h0, req.request_value[6:0]}));
                     end
                     REQ_SET_CONFIGURATION: begin
                        config_value = req.request_value;
                        acts.push_back(make_action(ACT_CFGSTORE, '0, {32'h0, config_value}, '0));
                        acts.push_back(make_action(ACT_ZLP, '0, '0, '0));
                     end
                     default: begin
                     end
                  endcase
               end else if (base_type == RT_DFU_CLASS) begin
                  if (req.request_code == CLS_GET_STATUS) begin
                     acts.push_back(make_action(ACT_SEND, 16'd6, {8'h00, state_byte, 32'h0}, '0));
                  end else if (req.request_code == CLS_GET_STATE) begin
                     acts.push_back(make_action(ACT_SEND, 16'd1, {40'h0, state_byte}, '0));
                  end else begin
                     if (req.request_code == CLS_DOWNLOAD) begin
                        download_mode = 1'b0;
                        if (req.request_length != '0) begin
                           page_sum      = 32'(app_base) + 32'(req.request_value) * PAGE_BYTES;
                           download_mode = 1'b1;
                           page_addr     = page_sum[ADDR_W-1:0];
                           page_armed    = 1'b1;
                        end
                     end
                     if (!page_armed) begin
                        acts.push_back(make_action(ACT_ZLP, '0, '0, '0));
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         if (acts.size() > 0) begin
            acts[acts.size() - 1].last = 1'b1;
         end
         foreach (acts[i]) begin
            expected_q.push_back(acts[i]);
         end
      endfunction

      task check_response(rsp_item_type got);
         rsp_item_type want;
         actions_checked++;
         if (expected_q.size() == 0) begin
            report_mismatch("action with none expected", 64'(got.action), '0);
            return;
         end
         want = expected_q.pop_front();
         if (got.action !== want.action) begin
            report_mismatch("action", 64'(got.action), 64'(want.action));
         end
         if (got.send_length !== want.send_length) begin
            report_mismatch("send_length", 64'(got.send_length), 64'(want.send_length));
         end
         if (got.payload !== want.payload) begin
            report_mismatch("payload", 64'(got.payload), 64'(want.payload));
         end
         if (got.target_address !== want.target_address) begin
            report_mismatch("target_address", 64'(got.target_address),
                            64'(want.target_address));
         end
         if (got.last !== want.last) begin
            report_mismatch("last", 64'(got.last), 64'(want.last));
         end
      endtask

      task check_drained();
         if (expected_q.size() != 0) begin
            report_mismatch("actions never delivered", 64'(expected_q.size()), '0);
         end
      endtask
   endclass

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data  = '0;

   dfu_scoreboard sb;
   int req_idle_pct = BASE_IDLE_PCT;
   int rsp_idle_pct = BASE_IDLE_PCT;
   int hold_trigger = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int cycle_count  = 0;
   int base_settings = 1;

   usb_dfu_control_request_handler #(
      .PAGE_BYTES    (PAGE_BYTES),
      .PAGES_PER_ROW (PAGES_PER_ROW)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** usb_dfu_control_request_handler: FAILED **");
         $finish;
      end
   end

   // Result side: checks each accepted beat and stalls at random or for a long hold.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
      end
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic req_item_type make_req(logic [1:0] ev, logic [7:0] rtype,
                                             logic [7:0] code, logic [15:0] value,
                                             logic [15:0] length);
      req_item_type item;
      item.event_req      = ev;
      item.request_type   = rtype;
      item.request_code   = code;
      item.request_value  = value;
      item.request_length = length;
      return item;
   endfunction

   function automatic logic [7:0] random_dir();
      return $urandom_range(1) ? DIR_IN : 8'h00;
   endfunction

   function automatic req_item_type random_request();
      req_item_type item;
      int pick;
      item = make_req(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      pick = $urandom_range(99);
      if (pick < 5) begin
         return item;
      end else if (pick < 13) begin
         item.event_req = EV_BUS_RESET;
      end else if (pick < 25) begin
         item.event_req = EV_OUT_DONE;
      end else begin
         item.event_req = EV_SETUP;
         case ($urandom_range(9))
            0, 1, 2: item.request_type = RT_STD_DEVICE | random_dir();
            3:       item.request_type = RT_STD_IFACE_OUT;
            4:       item.request_type = RT_STD_IFACE_OUT | DIR_IN;
            5, 6, 7: item.request_type = RT_DFU_CLASS | random_dir();
            default: begin
            end
         endcase
         case ($urandom_range(11))
            0:       item.request_code = REQ_GET_STATUS;
            1:       item.request_code = REQ_CLEAR_FEATURE;
            2:       item.request_code = REQ_SET_FEATURE;
            3:       item.request_code = REQ_SET_ADDRESS;
            4, 5:    item.request_code = REQ_GET_DESCRIPTOR;
            6:       item.request_code = REQ_GET_CONFIGURATION;
            7:       item.request_code = REQ_SET_CONFIGURATION;
            8:       item.request_code = CLS_DOWNLOAD;
            9:       item.request_code = CLS_GET_STATUS;
            10:      item.request_code = CLS_GET_STATE;
            default: begin
            end
         endcase
         if (item.request_code == REQ_GET_DESCRIPTOR && $urandom_range(3) != 0) begin
            item.request_value[15:8] = $urandom_range(1) ? DESC_DEVICE : DESC_CONFIG;
         end
         case ($urandom_range(3))
            0:       item.request_length = '0;
            1:       item.request_length = 16'($urandom_range(1, 64));
            default: begin
            end
         endcase
      end
      return item;
   endfunction

   task automatic send_request(input req_item_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_request(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_app_base(input logic [15:0] base);
      csr_data  <= base;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid   <= 1'b0;
      sb.app_base = base;
      base_settings++;
   endtask

   task automatic send_random_phase(input int count);
      req_item_type item;
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 30) begin
            send_request(make_req(EV_SETUP, RT_DFU_CLASS | random_dir(), CLS_DOWNLOAD,
                                  16'($urandom), 16'($urandom_range(1, 1024))));
            if ($urandom_range(1) != 0) begin
               send_request(make_req(EV_SETUP, RT_DFU_CLASS | DIR_IN, CLS_GET_STATUS,
                                     '0, 16'd6));
            end
            send_request(make_req(EV_OUT_DONE, 8'($urandom), 8'($urandom),
                                  16'($urandom), 16'($urandom)));
            send_request(make_req(EV_SETUP, RT_DFU_CLASS | DIR_IN, CLS_GET_STATUS,
                                  16'($urandom), 16'd6));
            sent += 4;
         end else begin
            item = random_request();
            send_request(item);
            if (item.event_req != EV_UNDEFINED) begin
               sent++;
            end
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_req(EV_BUS_RESET, '0, '0, '0, '0));
      send_request(make_req(EV_OUT_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
      send_request(make_req(EV_UNDEFINED, RT_STD_DEVICE, REQ_GET_STATUS, '0, 16'd2));
      send_request(make_req(EV_SETUP, RT_STD_IFACE_OUT, 8'($urandom), 16'($urandom), '0));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE | DIR_IN, REQ_GET_DESCRIPTOR,
                            16'h0100, 16'hFFFF));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE | DIR_IN, REQ_GET_DESCRIPTOR,
                            16'h0200, 16'h0012));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE | DIR_IN, REQ_GET_DESCRIPTOR,
                            16'h0300, 16'h00FF));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE | DIR_IN, REQ_GET_CONFIGURATION,
                            '0, 16'd1));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE | DIR_IN, REQ_GET_STATUS, '0, 16'd2));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE, REQ_CLEAR_FEATURE, 16'd1, '0));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE, REQ_SET_ADDRESS, 16'hFFFF, '0));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE, REQ_SET_CONFIGURATION, 16'hABCD, '0));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE | DIR_IN, REQ_GET_CONFIGURATION,
                            '0, 16'd1));
      send_request(make_req(EV_SETUP, RT_STD_DEVICE, 8'h07, '0, '0));
      send_request(make_req(EV_SETUP, 8'h40, REQ_GET_STATUS, '0, '0));
      send_request(make_req(EV_SETUP, RT_DFU_CLASS | DIR_IN, CLS_GET_STATUS, '0, 16'd6));
      send_request(make_req(EV_SETUP, RT_DFU_CLASS | DIR_IN, CLS_GET_STATE, '0, 16'd1));
      send_request(make_req(EV_SETUP, RT_DFU_CLASS, 8'h04, '0, '0));
      send_request(make_req(EV_SETUP, RT_DFU_CLASS, CLS_DOWNLOAD, '0, 16'd64));
      send_request(make_req(EV_SETUP, RT_DFU_CLASS | DIR_IN, CLS_GET_STATUS, '0, 16'd6));
      send_request(make_req(EV_SETUP, RT_DFU_CLASS, 8'h06, '0, '0));
      send_request(make_req(EV_SETUP, RT_DFU_CLASS, CLS_DOWNLOAD, 16'h0003, '0));
      send_request(make_req(EV_OUT_DONE, '0, '0, '0, '0));
      send_request(make_req(EV_SETUP, RT_DFU_CLASS, CLS_DOWNLOAD, 16'hFFFF, 16'hFFFF));
      send_request(make_req(EV_OUT_DONE, '0, '0, '0, '0));
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: write_app_base(16'h0000);
            2: write_app_base(16'hFFFF);
            default: begin
               if (phase > 0) begin
                  write_app_base(16'($urandom));
               end
            end
         endcase
         if (phase == 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = BASE_IDLE_PCT;
            rsp_idle_pct = BASE_IDLE_PCT;
         end
         if (phase == 3) begin
            hold_trigger <= hold_trigger + 1;
            req_idle_pct = 0;
            send_random_phase(36);
            req_idle_pct = BASE_IDLE_PCT;
            send_random_phase(PHASE_ITEMS - 36);
         end else begin
            send_random_phase(PHASE_ITEMS);
         end
         wait_drained();
      end

      sb.check_drained();
      $display("Covered %0d control events and %0d checked actions over %0d app_base settings,",
               sb.events_seen, sb.actions_checked, base_settings);
      $display("including %0d row erases, a long result hold and an unthrottled phase.",
               sb.erases_seen);
      if (sb.mismatches == 0) begin
         $display("** usb_dfu_control_request_handler: PASSED **");
      end else begin
         $display("** usb_dfu_control_request_handler: FAILED **");
      end
      $finish;
   end

endmodule
